// File: hw/rtl/ppg_pkg.sv
// Plasma pixel generator package: payload types, register indexes, sine ROM
// and RGB565 mixing functions. No dependencies.
package ppg_pkg;

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned ColorW  = 16;

  localparam logic [CfgIdxW-1:0] CfgBackground = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgAccent     = CfgIdxW'(1);

  localparam logic [ColorW-1:0] BackgroundReset = 16'h0000;
  localparam logic [ColorW-1:0] AccentReset     = 16'hFFFF;

  typedef struct packed {
    logic [7:0] pixel_x;
    logic [6:0] pixel_y;
    logic [8:0] frame_time;
  } pix_in_t;

  typedef struct packed {
    logic [ColorW-1:0] pixel_color;
    logic [7:0]        palette_index;
  } pix_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [ColorW-1:0]  data;
  } cfg_wr_t;

  // First quarter of the wave, 127*sin, entries 0..64
  function automatic logic [6:0] quarter_sine(logic [6:0] k);
    logic [6:0] r;
    case (k)
      7'd0:  r = 7'd0;   7'd1:  r = 7'd3;   7'd2:  r = 7'd6;   7'd3:  r = 7'd9;
      7'd4:  r = 7'd12;  7'd5:  r = 7'd15;  7'd6:  r = 7'd18;  7'd7:  r = 7'd21;
      7'd8:  r = 7'd24;  7'd9:  r = 7'd27;  7'd10: r = 7'd30;  7'd11: r = 7'd33;
      7'd12: r = 7'd36;  7'd13: r = 7'd39;  7'd14: r = 7'd42;  7'd15: r = 7'd45;
      7'd16: r = 7'd48;  7'd17: r = 7'd51;  7'd18: r = 7'd54;  7'd19: r = 7'd57;
      7'd20: r = 7'd59;  7'd21: r = 7'd62;  7'd22: r = 7'd65;  7'd23: r = 7'd67;
      7'd24: r = 7'd70;  7'd25: r = 7'd73;  7'd26: r = 7'd75;  7'd27: r = 7'd78;
      7'd28: r = 7'd80;  7'd29: r = 7'd82;  7'd30: r = 7'd85;  7'd31: r = 7'd87;
      7'd32: r = 7'd89;  7'd33: r = 7'd91;  7'd34: r = 7'd94;  7'd35: r = 7'd96;
      7'd36: r = 7'd98;  7'd37: r = 7'd100; 7'd38: r = 7'd102; 7'd39: r = 7'd103;
      7'd40: r = 7'd105; 7'd41: r = 7'd107; 7'd42: r = 7'd108; 7'd43: r = 7'd110;
      7'd44: r = 7'd112; 7'd45: r = 7'd113; 7'd46: r = 7'd114; 7'd47: r = 7'd116;
      7'd48: r = 7'd117; 7'd49: r = 7'd118; 7'd50: r = 7'd119; 7'd51: r = 7'd120;
      7'd52: r = 7'd121; 7'd53: r = 7'd122; 7'd54: r = 7'd123; 7'd55: r = 7'd123;
      7'd56: r = 7'd124; 7'd57: r = 7'd125; 7'd58: r = 7'd125; 7'd59: r = 7'd126;
      7'd60: r = 7'd126; 7'd61: r = 7'd126; 7'd62: r = 7'd126; 7'd63: r = 7'd126;
      7'd64: r = 7'd127;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  // Full wave from the quarter table, mirrored and negated by quadrant
  function automatic logic signed [7:0] sine(logic [7:0] a);
    logic [6:0] mag;
    if (!a[6]) begin
      mag = quarter_sine({1'b0, a[5:0]});
    end else begin
      mag = quarter_sine(7'd64 - {1'b0, a[5:0]});
    end
    return a[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  // ca + ((cb - ca) * s) / 64, quotient truncated toward zero
  function automatic logic [5:0] mix_ch(logic [5:0] ca, logic [5:0] cb, logic [5:0] s);
    logic signed [6:0]  diff;
    logic signed [13:0] prod;
    logic signed [13:0] adj;
    logic signed [13:0] quot;
    diff = $signed({1'b0, cb}) - $signed({1'b0, ca});
    prod = diff * $signed({1'b0, s});
    adj  = prod[13] ? prod + 14'sd63 : prod;
    quot = adj >>> 6;
    return ca + quot[5:0];
  endfunction

  function automatic logic [ColorW-1:0] mix565(logic [ColorW-1:0] a, logic [ColorW-1:0] b,
                                               logic [5:0] s);
    logic [5:0] r;
    logic [5:0] g;
    logic [5:0] bl;
    r  = mix_ch({1'b0, a[15:11]}, {1'b0, b[15:11]}, s);
    g  = mix_ch(a[10:5], b[10:5], s);
    bl = mix_ch({1'b0, a[4:0]}, {1'b0, b[4:0]}, s);
    return {r[4:0], g, bl[4:0]};
  endfunction

  // c + ((max - c) * 45) / 100; x/100 as (x * 1311) >> 17, exact for x < 4699
  function automatic logic [5:0] light_ch(logic [5:0] c, logic [5:0] cmax);
    logic [11:0] num;
    logic [22:0] prod;
    num  = 12'(cmax - c) * 12'd45;
    prod = 23'(num) * 23'd1311;
    return c + prod[22:17];
  endfunction

  function automatic logic [ColorW-1:0] light565(logic [ColorW-1:0] c);
    logic [5:0] r;
    logic [5:0] g;
    logic [5:0] bl;
    r  = light_ch({1'b0, c[15:11]}, 6'h1F);
    g  = light_ch(c[10:5], 6'h3F);
    bl = light_ch({1'b0, c[4:0]}, 6'h1F);
    return {r[4:0], g, bl[4:0]};
  endfunction

endpackage

// File: hw/rtl/ppg_stream_if.sv
// Valid/ready channel carrying one payload struct per transaction.
// Payload types come from ppg_pkg.
interface ppg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/plasma_pixel_generator.sv
// Plasma pixel generator top level: three-stage pixel pipeline plus theme registers.
// Depends on ppg_pkg and ppg_stream_if.
//
// Usage:
//   pixel_i carries one transaction per pixel (pixel_x, pixel_y, frame_time).
//   pixel_o returns one transaction per pixel (pixel_color in RGB565 and the
//   palette_index that picked it), in the order the pixels came in.
//   cfg_i writes theme registers: index 0 background, index 1 accent; other
//   indexes are dropped. cfg_i is always ready. Write only while no pixel
//   is in flight.
// Timing:
//   pixel_o.valid rises once the transaction has been registered in turn by
//   the input register, the palette index register and the result register.
//   While pixel_o is taken, one pixel per clock is sustained: input register,
//   palette index stage (three sine lookups, sum, constant scale), then the palette
//   mix into the result register. The light theme color is derived at the config write.
// Reset:
//   All stages go empty; background resets to 0x0000, accent to 0xFFFF.
// Stall:
//   When pixel_o is not taken, the pipeline fills up; pixel_i.ready drops
//   once all three stages hold a pixel and returns the cycle the output moves.
module plasma_pixel_generator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ppg_stream_if.sink                  pixel_i,
  ppg_stream_if.source                pixel_o,
  ppg_stream_if.sink                  cfg_i
);
  import ppg_pkg::*;

  logic [ColorW-1:0] bg_q;
  logic [ColorW-1:0] accent_q;
  logic [ColorW-1:0] light_q;

  logic       s1_valid_q, s2_valid_q, s3_valid_q;
  logic       s1_en, s2_en, s3_en;
  pix_in_t    s1_q;
  logic [7:0] idx_q;
  pix_out_t   s3_q;

  cfg_wr_t    cfg_wr;
  pix_in_t    pix_in;

  // ---------------- configuration ----------------
  assign cfg_wr      = cfg_i.payload;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q     <= BackgroundReset;
      accent_q <= AccentReset;
      light_q  <= AccentReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_wr.index)
        CfgBackground: bg_q <= cfg_wr.data;
        CfgAccent: begin
          accent_q <= cfg_wr.data;
          light_q  <= light565(cfg_wr.data);
        end
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  assign s3_en         = !s3_valid_q || pixel_o.ready;
  assign s2_en         = !s2_valid_q || s3_en;
  assign s1_en         = !s1_valid_q || s2_en;
  assign pixel_i.ready = s1_en;
  assign pix_in        = pixel_i.payload;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= pixel_i.valid;
      if (s2_en) s2_valid_q <= s1_valid_q;
      if (s3_en) s3_valid_q <= s2_valid_q;
    end
  end

  // ---------------- stage 1: input register ----------------
  always_ff @(posedge clk_i) begin
    if (s1_en && pixel_i.valid) begin
      s1_q <= pix_in;
    end
  end

  // ---------------- stage 2: palette index ----------------
  logic [7:0]        addr_a, addr_b, addr_c;
  logic signed [9:0] v_sum;
  logic [9:0]        w_off;
  logic [17:0]       w_scaled;
  logic [20:0]       m_div;
  logic [7:0]        idx_d;

  always_comb begin
    addr_a   = 8'(s1_q.pixel_x * 3) + s1_q.frame_time[7:0];
    addr_b   = {s1_q.pixel_y, 1'b0} - s1_q.frame_time[7:0];
    addr_c   = 8'({s1_q.pixel_x + 8'({1'b0, s1_q.pixel_y}), 1'b0}) + s1_q.frame_time[8:1];
    v_sum    = 10'(sine(addr_a)) + 10'(sine(addr_b)) + 10'(sine(addr_c));
    w_off    = 10'(v_sum + 10'sd384);
    // (w * 255) / 768 = ((w * 255) >> 8) / 3, and m / 3 = (m * 683) >> 11 for m < 2048
    w_scaled = {w_off, 8'b0} - 18'(w_off);
    m_div    = 21'(w_scaled[17:8]) * 21'd683;
    idx_d    = m_div[18:11];
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      idx_q <= idx_d;
    end
  end

  // ---------------- stage 3: palette mix ----------------
  logic [ColorW-1:0] mix_a, mix_b;
  pix_out_t          s3_d;

  always_comb begin
    case (idx_q[7:6])
      2'd0: begin mix_a = bg_q;     mix_b = accent_q; end
      2'd1: begin mix_a = accent_q; mix_b = light_q;  end
      2'd2: begin mix_a = light_q;  mix_b = accent_q; end
      default: begin mix_a = accent_q; mix_b = bg_q; end
    endcase
    s3_d.pixel_color   = mix565(mix_a, mix_b, idx_q[5:0]);
    s3_d.palette_index = idx_q;
  end

  always_ff @(posedge clk_i) begin
    if (s3_en && s2_valid_q) begin
      s3_q <= s3_d;
    end
  end

  assign pixel_o.valid   = s3_valid_q;
  assign pixel_o.payload = s3_q;

  // ---------------- assertions ----------------
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_i.valid && pixel_i.ready) |=> s1_valid_q)
    else $error("accepted pixel did not enter stage 1");

  a_s2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s2_en) |=> (s2_valid_q && $stable(idx_q)))
    else $error("stalled palette index was lost or changed");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> (s3_q.palette_index != 8'd255))
    else $error("palette index out of range");

  a_light_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    light_q == light565(accent_q))
    else $error("light color out of step with accent");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for plasma_pixel_generator: directed pixels, then random
// pixels under several themes. Depends on ppg_pkg, ppg_stream_if and plasma_pixel_generator from the RTL.
module testbench;
  import ppg_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 8;
  localparam int PHASE_PIXELS   = 167;
  localparam int DIRECTED_N     = 14;
  localparam int ROM_OFFSET     = 384;
  localparam int INDEX_SCALE    = 255;
  localparam int INDEX_DIV      = 768;
  localparam int SEG_STEPS      = 64;
  localparam int LIGHT_NUM      = 45;
  localparam int LIGHT_DEN      = 100;
  localparam logic [15:0] WHITE = 16'hFFFF;

  typedef enum logic [1:0] {
    SegBgToAccent,
    SegAccentToLight,
    SegLightToAccent,
    SegAccentToBg
  } palette_seg_e;

  typedef struct {
    pix_in_t  px;
    bit       known;
    pix_out_t res;
  } pixel_row_t;

  // Quarter wave of 127*sin, mirrored by quadrant
  int quarter_wave [65] = '{
      0,   3,   6,   9,  12,  15,  18,  21,  24,  27,  30,  33,  36,
     39,  42,  45,  48,  51,  54,  57,  59,  62,  65,  67,  70,  73,
     75,  78,  80,  82,  85,  87,  89,  91,  94,  96,  98, 100, 102,
    103, 105, 107, 108, 110, 112, 113, 114, 116, 117, 118, 119, 120,
    121, 122, 123, 123, 124, 125, 125, 126, 126, 126, 126, 126, 127
  };

  // All-zero sine sum lands on index 127, which is pure accent under the reset theme
  pixel_row_t directed_rows [DIRECTED_N] = '{
    '{'{8'd0,   7'd0,   9'd0},   1'b1, '{16'hFFFF, 8'd127}},
    '{'{8'd0,   7'd0,   9'd256}, 1'b1, '{16'hFFFF, 8'd127}},
    '{'{8'd159, 7'd119, 9'd511}, 1'b0, '{16'h0000, 8'd0}},
    '{'{8'd255, 7'd127, 9'd511}, 1'b0, '{16'h0000, 8'd0}},
    '{'{8'd160, 7'd0,   9'd0},   1'b0, '{16'h0000, 8'd0}},
    '{'{8'd0,   7'd120, 9'd0},   1'b0, '{16'h0000, 8'd0}},
    '{'{8'd255, 7'd0,   9'd0},   1'b0, '{16'h0000, 8'd0}},
    '{'{8'd0,   7'd127, 9'd0},   1'b0, '{16'h0000, 8'd0}},
    '{'{8'd0,   7'd0,   9'd1},   1'b0, '{16'h0000, 8'd0}},
    '{'{8'd0,   7'd0,   9'd511}, 1'b0, '{16'h0000, 8'd0}},
    '{'{8'hAA,  7'h2A,  9'h155}, 1'b0, '{16'h0000, 8'd0}},
    '{'{8'h55,  7'h55,  9'h0AA}, 1'b0, '{16'h0000, 8'd0}},
    '{'{8'd80,  7'd60,  9'd128}, 1'b0, '{16'h0000, 8'd0}},
    '{'{8'd1,   7'd1,   9'd3},   1'b0, '{16'h0000, 8'd0}}
  };

  logic [15:0] theme_bg_list     [5] = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'hF800, 16'h001F};
  logic [15:0] theme_accent_list [5] = '{16'h0000, 16'h0000, 16'hFFFF, 16'h07E0, 16'hFFE0};

  logic clk;
  logic rst_n;

  ppg_stream_if #(.payload_t(pix_in_t))  pix_in_if ();
  ppg_stream_if #(.payload_t(pix_out_t)) pix_out_if ();
  ppg_stream_if #(.payload_t(cfg_wr_t))  cfg_if ();

  plasma_pixel_generator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pixel_i(pix_in_if),
    .pixel_o(pix_out_if),
    .cfg_i  (cfg_if)
  );

  logic [15:0] theme_bg;
  logic [15:0] theme_accent;
  pix_out_t    pending_pixels[$];
  int          errors;
  int          send_run;
  int          recv_run;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int wave(int addr);
    int a;
    int k;
    int q;
    int mag;
    a = addr & 255;
    k = a & 63;
    q = a >> 6;
    mag = (q == 0 || q == 2) ? quarter_wave[k] : quarter_wave[64 - k];
    return (q >= 2) ? -mag : mag;
  endfunction

  function automatic int fade(int ca, int cb, int n, int d);
    return ca + ((cb - ca) * n) / d;
  endfunction

  function automatic logic [15:0] blend565(logic [15:0] a, logic [15:0] b, int n, int d);
    int r;
    int g;
    int bl;
    r  = fade(int'(a[15:11]), int'(b[15:11]), n, d);
    g  = fade(int'(a[10:5]), int'(b[10:5]), n, d);
    bl = fade(int'(a[4:0]), int'(b[4:0]), n, d);
    return {r[4:0], g[5:0], bl[4:0]};
  endfunction

  function automatic logic [15:0] theme_palette(logic [7:0] idx);
    logic [15:0] light;
    int s;
    light = blend565(theme_accent, WHITE, LIGHT_NUM, LIGHT_DEN);
    s = int'(idx[5:0]);
    case (palette_seg_e'(idx[7:6]))
      SegBgToAccent:    return blend565(theme_bg, theme_accent, s, SEG_STEPS);
      SegAccentToLight: return blend565(theme_accent, light, s, SEG_STEPS);
      SegLightToAccent: return blend565(light, theme_accent, s, SEG_STEPS);
      default:          return blend565(theme_accent, theme_bg, s, SEG_STEPS);
    endcase
  endfunction

  function automatic pix_out_t plasma_color(pix_in_t px);
    pix_out_t res;
    int x;
    int y;
    int t;
    int v;
    int idx;
    x = int'(px.pixel_x);
    y = int'(px.pixel_y);
    t = int'(px.frame_time);
    v = wave(3 * x + t) + wave(2 * y - t) + wave(2 * (x + y) + (t >> 1));
    idx = ((v + ROM_OFFSET) * INDEX_SCALE) / INDEX_DIV;
    res.palette_index = idx[7:0];
    res.pixel_color   = theme_palette(idx[7:0]);
    return res;
  endfunction

  // ---------------------------------------------------------------- helpers

  // Random wait with occasional zero-wait bursts
  function automatic int draw_wait(ref int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      run_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  function automatic pix_in_t rand_pixel();
    pix_in_t px;
    if ($urandom_range(0, 3) == 0) begin
      px.pixel_x = 8'($urandom_range(0, 255));
      px.pixel_y = 7'($urandom_range(0, 127));
    end else begin
      px.pixel_x = 8'($urandom_range(0, 159));
      px.pixel_y = 7'($urandom_range(0, 119));
    end
    px.frame_time = 9'($urandom_range(0, 511));
    return px;
  endfunction

  task automatic send_pixel(pix_in_t px, bit known, pix_out_t res);
    int gap;
    gap = draw_wait(send_run);
    if (gap > 0) begin
      pix_in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in_if.valid   <= 1'b1;
    pix_in_if.payload <= px;
    do @(posedge clk); while (!pix_in_if.ready);
    pending_pixels.push_back(known ? res : plasma_color(px));
  endtask

  // Hold off the pixel stream until every result is back
  task automatic pause_pixels();
    pix_in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [ColorW-1:0] data);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= '{index: idx, data: data};
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == CfgBackground) begin
      theme_bg = data;
    end else if (idx == CfgAccent) begin
      theme_accent = data;
    end
  endtask

  task automatic load_theme(logic [15:0] bg, logic [15:0] ac);
    // unused index first, must be dropped
    cfg_write(CfgIdxW'($urandom_range(2, 255)), 16'($urandom));
    cfg_write(CfgBackground, bg);
    cfg_write(CfgAccent, ac);
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    pix_in_t     px;
    pix_out_t    none;
    logic [15:0] bg;
    logic [15:0] ac;
    rst_n             = 1'b0;
    pix_in_if.valid   = 1'b0;
    pix_in_if.payload = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.payload    = '0;
    none              = '0;
    errors            = 0;
    send_run          = 0;
    theme_bg          = BackgroundReset;
    theme_accent      = AccentReset;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].px, directed_rows[i].known, directed_rows[i].res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      pause_pixels();
      if (ph < 5) begin
        bg = theme_bg_list[ph];
        ac = theme_accent_list[ph];
      end else begin
        bg = 16'($urandom);
        ac = 16'($urandom);
      end
      load_theme(bg, ac);
      for (int j = 0; j < PHASE_PIXELS; j++) begin
        if (j == PHASE_PIXELS / 2) begin
          pause_pixels();
        end
        px = rand_pixel();
        send_pixel(px, 1'b0, none);
      end
    end

    pause_pixels();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------- results

  initial begin : result_sink
    pix_out_t got;
    pix_out_t want;
    int       stall;
    pix_out_if.ready = 1'b0;
    recv_run = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_wait(recv_run);
      if (stall > 0) begin
        pix_out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pix_out_if.ready <= 1'b1;
      do @(posedge clk); while (!pix_out_if.valid);
      got = pix_out_if.payload;
      if (pending_pixels.size() == 0) begin
        note_error($sformatf("unexpected transaction color=%h index=%0d",
                             got.pixel_color, got.palette_index));
      end else begin
        want = pending_pixels.pop_front();
        if (got.pixel_color !== want.pixel_color) begin
          note_error($sformatf("pixel_color expected %h actual %h",
                               want.pixel_color, got.pixel_color));
        end
        if (got.palette_index !== want.palette_index) begin
          note_error($sformatf("palette_index expected %0d actual %0d",
                               want.palette_index, got.palette_index));
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  initial begin : watchdog
    int quiet;
    quiet = 0;
    do @(posedge clk); while (!rst_n);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((pix_in_if.valid && pix_in_if.ready) || (pix_out_if.valid && pix_out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[%0t] timeout, %0d results outstanding", $realtime, pending_pixels.size());
    $display("testbench: errors");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ppg_pkg.sv
hw/rtl/ppg_stream_if.sv
hw/rtl/plasma_pixel_generator.sv
verif/testbench.sv
